FILE: rtl/crau_pkg.sv
// ----------------------------------------------------------------------------
// crau_pkg
// Shared widths, register indexes, job type and back-end states of the
// counter rate accumulator.
// ----------------------------------------------------------------------------
package crau_pkg;

  localparam int TIME_W    = 48;
  localparam int VALUE_W   = 48;
  localparam int DELTA_W   = VALUE_W + 1;
  localparam int MAG_W     = 64;
  localparam int MS_W      = 10;
  localparam int PROD_W    = MAG_W + MS_W;
  localparam int HI_W      = PROD_W - VALUE_W;
  localparam int CNT_W     = 6;
  localparam int MS_PER_S  = 1000;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = TIME_W + VALUE_W;
  localparam int OUT_USER_W = 2;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE_BY_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTANT_MODE   = 2'd2;

  localparam logic [MAG_W-1:0] POS_LIMIT = (MAG_W'(1) << (VALUE_W - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1) << (VALUE_W - 1);
  localparam logic [MAG_W-1:0] QUOT_CAP  = MAG_W'(1) << VALUE_W;

  typedef struct packed {
    logic [MAG_W-1:0]  inc;
    logic [TIME_W-1:0] span;
    logic              use_div;
    logic              degen;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ABS,
    B_MUL,
    B_CHK,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

FILE: rtl/crau_front.sv
// ----------------------------------------------------------------------------
// crau_front
// Takes samples, keeps the series state and turns the last sample of a
// series into a job for the back end.
// ----------------------------------------------------------------------------
module crau_front import crau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [TIME_W-1:0]    timestamp_ms,
  input  logic [VALUE_W-1:0]   sample_value,
  input  logic                 last_of_series,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_wdata
);

  logic               counter_mode_r;
  logic               divide_by_time_r;
  logic               instant_mode_r;
  logic               have_r;
  logic               have_nxt;
  logic [TIME_W-1:0]  first_time_r;
  logic [TIME_W-1:0]  prev_time_r;
  logic [VALUE_W-1:0] first_value_r;
  logic [VALUE_W-1:0] prev_value_r;
  logic [MAG_W-1:0]   run_inc_r;
  logic [MAG_W-1:0]   run_inc_nxt;

  logic               accept;
  logic               v_lt_prev;
  logic [DELTA_W-1:0] v_ext;
  logic [DELTA_W-1:0] step_diff;
  logic [DELTA_W-1:0] step_d;
  logic [MAG_W-1:0]   step_d64;
  logic [MAG_W-1:0]   sum;
  logic               ovf_pos;
  logic               ovf_neg;
  logic [DELTA_W-1:0] gauge_d;

  assign s_ready = !q_full;
  assign accept  = s_valid && !q_full;
  assign q_push  = accept && last_of_series;

  // counter step: a drop counts as a reset to zero
  assign v_lt_prev = $signed(sample_value) < $signed(prev_value_r);
  assign v_ext     = {sample_value[VALUE_W-1], sample_value};
  assign step_diff = v_ext - {prev_value_r[VALUE_W-1], prev_value_r};
  assign step_d    = v_lt_prev ? v_ext : step_diff;
  assign step_d64  = {{(MAG_W-DELTA_W){step_d[DELTA_W-1]}}, step_d};
  assign gauge_d   = v_ext - {first_value_r[VALUE_W-1], first_value_r};

  assign sum     = run_inc_r + step_d64;
  assign ovf_pos = !run_inc_r[MAG_W-1] && !step_d64[MAG_W-1] && sum[MAG_W-1];
  assign ovf_neg = run_inc_r[MAG_W-1] && step_d64[MAG_W-1] && !sum[MAG_W-1];

  always_comb begin
    if (!have_r) begin
      run_inc_nxt = '0;
    end else if (ovf_pos) begin
      run_inc_nxt = {1'b0, {(MAG_W-1){1'b1}}};
    end else if (ovf_neg) begin
      run_inc_nxt = {1'b1, {(MAG_W-1){1'b0}}};
    end else begin
      run_inc_nxt = sum;
    end
  end

  always_comb begin
    if (instant_mode_r) begin
      q_wdata.inc     = step_d64;
      q_wdata.span    = timestamp_ms - prev_time_r;
      q_wdata.use_div = 1'b1;
      q_wdata.degen   = !have_r || (timestamp_ms <= prev_time_r);
    end else begin
      q_wdata.inc     = counter_mode_r ? run_inc_nxt
                                       : {{(MAG_W-DELTA_W){gauge_d[DELTA_W-1]}}, gauge_d};
      q_wdata.span    = timestamp_ms - first_time_r;
      q_wdata.use_div = divide_by_time_r;
      q_wdata.degen   = !have_r || (timestamp_ms <= first_time_r);
    end
  end

  assign have_nxt = accept ? !last_of_series : have_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r           <= 1'b0;
      counter_mode_r   <= 1'b1;
      divide_by_time_r <= 1'b1;
      instant_mode_r   <= 1'b0;
    end else begin
      have_r <= have_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTER_MODE:   counter_mode_r   <= cfg_wdata;
          CFG_DIVIDE_BY_TIME: divide_by_time_r <= cfg_wdata;
          CFG_INSTANT_MODE:   instant_mode_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!have_r) begin
        first_time_r  <= timestamp_ms;
        first_value_r <= sample_value;
      end
      prev_time_r  <= timestamp_ms;
      prev_value_r <= sample_value;
      run_inc_r    <= run_inc_nxt;
    end
  end

endmodule

FILE: rtl/crau_queue.sv
// ----------------------------------------------------------------------------
// crau_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module crau_queue import crau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic full,
  output logic empty
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;

  assign full  = count_r == Q_CNT_W'(Q_DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/crau_back.sv
// ----------------------------------------------------------------------------
// crau_back
// Carries out one job: magnitude, then, when dividing, scaling by 1000 and
// bit-serial division by the span, then clamping and the output register.
// ----------------------------------------------------------------------------
module crau_back import crau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  job_t               q_rdata,
  output logic               q_pop,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [VALUE_W-1:0] rate_value,
  output logic               degenerate,
  output logic               saturated
);

  back_state_t        state_r;
  back_state_t        state_nxt;
  job_t               job_r;
  logic               neg_r;
  logic [MAG_W-1:0]   mag_r;
  logic [PROD_W-1:0]  prod_r;
  logic [TIME_W-1:0]  rem_r;
  logic [VALUE_W-1:0] quot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] result_r;
  logic               degen_r;
  logic               sat_r;

  logic               out_free;
  logic               out_load;
  logic [HI_W-1:0]    prod_hi;
  logic               quot_ovf;
  logic               div_last;
  logic [TIME_W:0]    rem_sh;
  logic [TIME_W:0]    rem_diff;
  logic               q_bit;
  logic [TIME_W-1:0]  rem_nxt;
  logic [VALUE_W-1:0] quot_nxt;
  logic [MAG_W-1:0]   mag_neg;
  logic [VALUE_W-1:0] res_val;
  logic               res_degen;
  logic               res_sat;

  assign out_free = !out_valid_r || m_ready;
  assign prod_hi  = prod_r[PROD_W-1:VALUE_W];
  assign quot_ovf = {{(TIME_W-HI_W){1'b0}}, prod_hi} >= job_r.span;
  assign div_last = cnt_r == CNT_W'(VALUE_W - 1);

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r, quot_r[VALUE_W-1]};
  assign rem_diff = rem_sh - {1'b0, job_r.span};
  assign q_bit    = !rem_diff[TIME_W];
  assign rem_nxt  = q_bit ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
  assign quot_nxt = {quot_r[VALUE_W-2:0], q_bit};

  assign mag_neg = MAG_W'(0) - mag_r;

  always_comb begin
    res_val   = '0;
    res_degen = 1'b0;
    res_sat   = 1'b0;
    if (job_r.degen) begin
      res_degen = 1'b1;
    end else if (neg_r) begin
      if (mag_r > NEG_LIMIT) begin
        res_sat = 1'b1;
        res_val = NEG_LIMIT[VALUE_W-1:0];
      end else begin
        res_val = mag_neg[VALUE_W-1:0];
      end
    end else if (mag_r > POS_LIMIT) begin
      res_sat = 1'b1;
      res_val = POS_LIMIT[VALUE_W-1:0];
    end else begin
      res_val = mag_r[VALUE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_ABS;
        end
      end
      B_ABS: begin
        state_nxt = (job_r.degen || !job_r.use_div) ? B_FIN : B_MUL;
      end
      B_MUL: state_nxt = B_CHK;
      B_CHK: state_nxt = quot_ovf ? B_FIN : B_DIV;
      B_DIV: begin
        if (div_last) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      B_IDLE:  q_pop    = !q_empty;
      B_FIN:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (m_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_rdata;
    end
    case (state_r)
      B_ABS: begin
        neg_r <= job_r.inc[MAG_W-1];
        mag_r <= job_r.inc[MAG_W-1] ? (MAG_W'(0) - job_r.inc) : job_r.inc;
      end
      B_MUL: prod_r <= {{MS_W{1'b0}}, mag_r} * PROD_W'(MS_PER_S);
      B_CHK: begin
        if (quot_ovf) begin
          mag_r <= QUOT_CAP;
        end
        rem_r  <= {{(TIME_W-HI_W){1'b0}}, prod_hi};
        quot_r <= prod_r[VALUE_W-1:0];
        cnt_r  <= '0;
      end
      B_DIV: begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
        mag_r  <= {{(MAG_W-VALUE_W){1'b0}}, quot_nxt};
      end
      default: ;
    endcase
    if (out_load) begin
      result_r <= res_val;
      degen_r  <= res_degen;
      sat_r    <= res_sat;
    end
  end

  assign m_valid    = out_valid_r;
  assign rate_value = result_r;
  assign degenerate = degen_r;
  assign saturated  = sat_r;

endmodule

FILE: rtl/counter_rate_accumulator_unit.sv
// ----------------------------------------------------------------------------
// counter_rate_accumulator_unit
// Increase or per-second rate of a sample series with counter reset handling.
// ----------------------------------------------------------------------------
// Samples of one series arrive on the in_ stream, oldest first, one transfer
// per cycle while the job queue has room; in_tlast marks the last sample of a
// series. Each series gives one transfer on the out_ stream: the increase or
// rate, a degenerate flag and a saturated flag. Mode registers are to be
// written on the cfg_ port only while idle; the block itself does not enforce
// this. They are read at the last sample. Samples are taken every cycle while
// the two-entry job queue has room. The last sample becomes a job; the back
// end runs it through B_ABS and B_FIN without division, through B_ABS, B_MUL,
// B_CHK and B_FIN when the quotient overflows, and with division also through
// the 48-step bit-serial divider in B_DIV. It takes the next job only after
// loading its result; short series stall in_tready once two jobs are queued.
// Reset sets counter_mode and divide_by_time to 1, instant_mode to 0, and
// empties the series state, the queue and the output register.
// When the receiver stalls, the result holds in the output register, the back
// end waits with the next result, and then the queue fills and stops input.
// ----------------------------------------------------------------------------
module counter_rate_accumulator_unit import crau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // timestamp_ms, sample_value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VALUE_W-1:0]    out_tdata,  // rate_value
  output logic [OUT_USER_W-1:0] out_tuser,  // degenerate, saturated
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_wdata
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_wdata;
  job_t q_rdata;
  logic degenerate;
  logic saturated;

  crau_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .s_valid        (in_tvalid),
    .s_ready        (in_tready),
    .timestamp_ms   (in_tdata[TIME_W-1:0]),
    .sample_value   (in_tdata[TIME_W +: VALUE_W]),
    .last_of_series (in_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  crau_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  crau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .m_valid    (out_tvalid),
    .m_ready    (out_tready),
    .rate_value (out_tdata),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

  assign out_tuser = {saturated, degenerate};

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("degenerate result not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata == POS_LIMIT[VALUE_W-1:0] || out_tdata == NEG_LIMIT[VALUE_W-1:0])
    else $error("saturated result not at a limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

endmodule

FILE: tb/counter_rate_accumulator_unit_checker.sv
// ----------------------------------------------------------------------------
// counter_rate_accumulator_unit_checker
// Watches the in_, out_ and cfg_ ports, predicts one result per series from
// its own copy of the mode registers and series state, and compares each
// result transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module counter_rate_accumulator_unit_checker import crau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // timestamp_ms, sample_value
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [VALUE_W-1:0]    out_tdata,  // rate_value
  input  logic [OUT_USER_W-1:0] out_tuser,  // degenerate, saturated
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           outstanding
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               degen;
    logic               sat;
  } series_result_t;

  localparam longint INC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint INC_MIN = 64'sh8000_0000_0000_0000;

  logic              counter_mode;
  logic              divide_by_time;
  logic              instant_mode;
  logic [TIME_W-1:0] first_time;
  logic [TIME_W-1:0] prev_time;
  longint            first_value;
  longint            prev_value;
  longint            running_increase;
  int unsigned       seen_count;
  int unsigned       mismatch_total = 0;
  series_result_t    predicted_results[$];
  series_result_t    oldest;

  task automatic clear_series();
    first_time       = '0;
    prev_time        = '0;
    first_value      = 0;
    prev_value       = 0;
    running_increase = 0;
    seen_count       = 0;
  endtask

  // floor(mag * 1000 / span), capped at 2^48
  function automatic logic [MAG_W-1:0] per_second(input logic [MAG_W-1:0] mag,
                                                  input logic [TIME_W-1:0] span_ms);
    logic [127:0] quot;
    quot = ({64'd0, mag} * 128'(MS_PER_S)) / {80'd0, span_ms};
    return (quot > 128'(QUOT_CAP)) ? QUOT_CAP : quot[MAG_W-1:0];
  endfunction

  function automatic series_result_t clamp_result(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
    series_result_t   r;
    logic [MAG_W-1:0] m;
    m       = mag;
    r.degen = 1'b0;
    r.sat   = 1'b0;
    if (neg) begin
      if (m > NEG_LIMIT) begin
        r.sat = 1'b1;
        m     = NEG_LIMIT;
      end
      r.value = VALUE_W'(MAG_W'(0) - m);
    end else begin
      if (m > POS_LIMIT) begin
        r.sat = 1'b1;
        m     = POS_LIMIT;
      end
      r.value = VALUE_W'(m);
    end
    return r;
  endfunction

  task automatic take_sample(input logic [TIME_W-1:0] t, input logic [VALUE_W-1:0] raw,
                             input logic last);
    longint             v;
    longint             d;
    longint             inc;
    logic signed [64:0] wide;
    logic [MAG_W-1:0]   mag;
    series_result_t     r;
    v = {{(64-VALUE_W){raw[VALUE_W-1]}}, raw};
    if (seen_count == 0) begin
      first_time       = t;
      first_value      = v;
      running_increase = 0;
    end else begin
      // a drop counts as a counter restart from zero
      d    = (v < prev_value) ? v : v - prev_value;
      wide = {running_increase[63], running_increase} + {d[63], d};
      if (wide[64] != wide[63]) running_increase = wide[64] ? INC_MIN : INC_MAX;
      else running_increase = wide[63:0];
    end
    if (!last) begin
      prev_time  = t;
      prev_value = v;
      if (seen_count < 2) seen_count++;
    end else begin
      r.value = '0;
      r.degen = 1'b0;
      r.sat   = 1'b0;
      if (seen_count == 0) begin
        r.degen = 1'b1;
      end else if (instant_mode) begin
        if (t <= prev_time) begin
          r.degen = 1'b1;
        end else begin
          d = v - prev_value;
          if (d < 0) d = v;
          mag = (d < 0) ? MAG_W'(-d) : MAG_W'(d);
          r   = clamp_result(d < 0, per_second(mag, t - prev_time));
        end
      end else if (t <= first_time) begin
        r.degen = 1'b1;
      end else begin
        inc = counter_mode ? running_increase : v - first_value;
        mag = (inc < 0) ? MAG_W'(-inc) : MAG_W'(inc);
        if (divide_by_time) mag = per_second(mag, t - first_time);
        r = clamp_result(inc < 0, mag);
      end
      predicted_results.insert(predicted_results.size(), r);
      clear_series();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      counter_mode   = 1'b1;
      divide_by_time = 1'b1;
      instant_mode   = 1'b0;
      clear_series();
      predicted_results.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with nothing pending: rate_value %h flags %b",
                 out_tdata, out_tuser);
          mismatch_total++;
        end else begin
          oldest = predicted_results.pop_front();
          if (out_tdata !== oldest.value) begin
            $error("rate_value mismatch: expected %h, got %h", oldest.value, out_tdata);
            mismatch_total++;
          end
          if (out_tuser[0] !== oldest.degen) begin
            $error("degenerate mismatch: expected %b, got %b", oldest.degen, out_tuser[0]);
            mismatch_total++;
          end
          if (out_tuser[1] !== oldest.sat) begin
            $error("saturated mismatch: expected %b, got %b", oldest.sat, out_tuser[1]);
            mismatch_total++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTER_MODE:   counter_mode   = cfg_wdata;
          CFG_DIVIDE_BY_TIME: divide_by_time = cfg_wdata;
          CFG_INSTANT_MODE:   instant_mode   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        take_sample(in_tdata[TIME_W-1:0], in_tdata[IN_DATA_W-1:TIME_W], in_tlast);
      outstanding <= predicted_results.size();
    end
    fail_count <= mismatch_total;
  end

endmodule

FILE: tb/counter_rate_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// counter_rate_accumulator_unit_test
// Drives sample series into the unit under random idling and backpressure,
// first a handful of directed corner series, then random series under all
// eight mode settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module counter_rate_accumulator_unit_test;
  import crau_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned          ITEM_TARGET      = 950;
  localparam int unsigned          SETTLE_CYCLES    = 64;
  localparam int unsigned          CYCLE_LIMIT      = 1000000;
  localparam logic [VALUE_W-1:0]   VALUE_MIN        = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0]   VALUE_MAX        = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [TIME_W-1:0]    TIME_MAX         = '1;
  localparam logic [VALUE_W-1:0]   ONE              = VALUE_W'(1) << 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [VALUE_W-1:0]    out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic                  cfg_wdata;
  int unsigned           fail_count;
  int unsigned           outstanding;
  int unsigned           items_sent;
  int unsigned           cycle_count;
  logic                  tx_steady;

  counter_rate_accumulator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  counter_rate_accumulator_unit_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL counter_rate_accumulator_unit");
    $finish;
  end

  // receiver: short stalls, a few long ones, and quiet stretches
  initial begin
    int unsigned r;
    int unsigned stall_left;
    int unsigned quiet_left;
    stall_left = 0;
    quiet_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_left > 0) begin
        quiet_left--;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 999);
        out_tready <= 1'b1;
        if (r < 5) quiet_left = $urandom_range(100, 400);
        else if (r < 15) stall_left = $urandom_range(20, 80);
        else if (r < 150) stall_left = $urandom_range(1, 3);
      end
    end
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VALUE_W-1:0] v,
                             input logic last);
    int unsigned r;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {v, t};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!tx_steady) begin
      r   = $urandom_range(0, 99);
      gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    logic [24:0] s;
    r = $urandom_range(0, 99);
    s = 25'($urandom);
    if (r < 5) return VALUE_MIN;
    if (r < 10) return VALUE_MAX;
    if (r < 15) return '0;
    if (r < 40) return VALUE_W'({$urandom, $urandom});
    return {{(VALUE_W-25){s[24]}}, s};
  endfunction

  task automatic send_series();
    int unsigned       r;
    int unsigned       len;
    int unsigned       k;
    logic [TIME_W-1:0] t;
    logic [VALUE_W-1:0] v;
    r   = $urandom_range(0, 99);
    len = (r < 15) ? 1 : (r < 90) ? $urandom_range(2, 8) : $urandom_range(9, 40);
    tx_steady = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (r < 3) t = TIME_W'({$urandom, $urandom});
    else if (r < 4) t = TIME_MAX - TIME_W'($urandom_range(0, 20000));
    else t = TIME_W'($urandom);
    v = pick_value();
    for (k = 0; k < len; k++) begin
      send_sample(t, v, k == len - 1);
      r = $urandom_range(0, 99);
      if (r < 5) t = t - TIME_W'($urandom_range(1, 5000));
      else if (r < 8) t = t + TIME_W'({$urandom, $urandom});
      else if (r >= 12) t = t + TIME_W'($urandom_range(1, 3000));
      // otherwise the timestamp repeats
      r = $urandom_range(0, 99);
      if (r < 10) v = VALUE_W'($urandom_range(0, 1000));
      else if (r < 15) v = pick_value();
      else if (r < 30) v = v - VALUE_W'($urandom >> $urandom_range(0, 31));
      else v = v + VALUE_W'($urandom >> $urandom_range(0, 31));
    end
  endtask

  // stop sending and wait for every pending result plus the back-end latency
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_COUNTER_MODE;
    cfg_wdata <= 1'b0;
    items_sent = 0;
    tx_steady  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single sample
    send_sample(48'd1000, '0, 1'b1);
    // plain rate
    send_sample(48'd0, '0, 1'b0);
    send_sample(48'd2000, 5 * ONE, 1'b1);
    // counter restart inside the series
    send_sample(48'd100, 10 * ONE, 1'b0);
    send_sample(48'd200, 4 * ONE, 1'b0);
    send_sample(48'd300, 20 * ONE, 1'b0);
    send_sample(48'd1100, 25 * ONE, 1'b1);
    // time going backwards
    send_sample(48'd5000, VALUE_W'(1), 1'b0);
    send_sample(48'd4000, VALUE_W'(2), 1'b1);
    // zero span
    send_sample(48'd7000, VALUE_W'(1), 1'b0);
    send_sample(48'd7000, VALUE_W'(9), 1'b1);
    // positive saturation
    send_sample(48'd10, VALUE_MIN, 1'b0);
    send_sample(48'd11, VALUE_MAX, 1'b1);
    // negative saturation
    send_sample(48'd20, '0, 1'b0);
    send_sample(48'd21, VALUE_MIN, 1'b1);
    // timestamp extremes
    send_sample('0, ONE, 1'b0);
    send_sample(TIME_MAX, VALUE_MAX, 1'b1);
    send_sample(TIME_MAX - 2, '1, 1'b0);
    send_sample(TIME_MAX - 1, '1, 1'b0);
    send_sample(TIME_MAX, '1, 1'b1);
    send_sample(TIME_MAX, '1, 1'b1);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_COUNTER_MODE;
      cfg_wdata <= phase[0];
      @(posedge clk);
      cfg_index <= CFG_DIVIDE_BY_TIME;
      cfg_wdata <= phase[1];
      @(posedge clk);
      cfg_index <= CFG_INSTANT_MODE;
      cfg_wdata <= phase[2];
      @(posedge clk);
      cfg_index <= CFG_UNUSED_INDEX;
      cfg_wdata <= 1'($urandom_range(0, 1));
      @(posedge clk);
      cfg_we <= 1'b0;
      while (items_sent < ITEM_TARGET * (phase + 1) / 8) send_series();
      drain();
    end

    if (fail_count == 0) $display("PASS counter_rate_accumulator_unit");
    else $display("FAIL counter_rate_accumulator_unit");
    $finish;
  end

endmodule
